// File: hw/rtl/bfa_pkg.sv
`timescale 1ns / 1ps
package bfa_pkg;

  localparam int NUM_BLOCKS  = 4096;
  localparam int BLOCK_BYTES = 512;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int IDX_W       = $clog2(NUM_BLOCKS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int VAL_W       = CNT_W;
  localparam int ENTRY_W     = VAL_W + 2;
  localparam int BYTES_W     = 22;
  localparam int NEED_W      = BYTES_W - BLOCK_SHIFT + 1;
  localparam int WALK_W      = CNT_W + 1;

  // table entry: start holds run length, middle holds its run's start
  typedef struct packed {
    logic             alloc;
    logic             mid;
    logic [VAL_W-1:0] val;
  } entry_t;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LOW_FREE  = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NOT_START = 3'd4,
    ST_ZERO_SIZE = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_A_RD,
    S_A_CHK,
    S_A_WR,
    S_F_RD0,
    S_F_CHK0,
    S_F_RD1,
    S_F_CHK1,
    S_F_RD2,
    S_F_CHK2,
    S_F_WR,
    S_RESP
  } state_t;

endpackage

// File: hw/rtl/bfa_if.sv
`timescale 1ns / 1ps
interface bfa_req_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [BYTES_W-1:0] request_bytes;
  logic [11:0]        release_block;

  modport source (output valid, opcode, request_bytes, release_block, input ready);
  modport sink (input valid, opcode, request_bytes, release_block, output ready);
endinterface

interface bfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] start_block;
  logic [12:0] free_block_count;

  modport source (output valid, status, start_block, free_block_count, input ready);
  modport sink (input valid, status, start_block, free_block_count, output ready);
endinterface

// File: hw/rtl/best_fit_block_allocator.sv
`timescale 1ns / 1ps
// channel   | dir | handshake             | payload
// in_req    | in  | valid/ready           | opcode, request_bytes, release_block
// out_rsp   | out | valid/ready           | status, start_block, free_block_count
// cfg       | in  | cfg_wr_en, no stall   | cfg_wr_data = active_blocks
//
// one request at a time through a single-port table ram, one access a cycle
// allocate: a best-fit walk reads and then checks each run in turn, then a
//   write sweep over every block of the chosen run does the split
// free: reads the released run and its neighbors, then rewrites the merged free run
// after reset and after each cfg write an init pass rewrites one table entry per
//   active block (4096 after reset); in_req is not ready meanwhile
// a finished result waits in the output register while the next request runs
module best_fit_block_allocator import bfa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  bfa_req_if.sink          in_req,
  bfa_rsp_if.source        out_rsp,
  input  logic             cfg_wr_en,
  input  logic [12:0]      cfg_wr_data
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  active_r, active_nxt;
  logic [CNT_W-1:0]  free_total_r, free_total_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [WALK_W-1:0] walk_r, walk_nxt;
  logic [IDX_W-1:0]  best_r, best_nxt;
  logic [VAL_W-1:0]  best_len_r, best_len_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  rel_r, rel_nxt;
  logic [IDX_W-1:0]  run_start_r, run_start_nxt;
  logic [CNT_W-1:0]  run_end_r, run_end_nxt;
  logic [CNT_W-1:0]  wptr_r, wptr_nxt;
  status_t           status_r, status_nxt;
  logic [IDX_W-1:0]  start_blk_r, start_blk_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [IDX_W-1:0]  out_start_r, out_start_nxt;
  logic [CNT_W-1:0]  out_free_r, out_free_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  entry_t            ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd;

  logic              in_fire;
  logic [BYTES_W:0]  bytes_up;
  logic [NEED_W-1:0] need_c;
  logic [CNT_W-1:0]  cfg_clamped;
  logic              a_end, a_skip, a_hit, a_exact, a_wr_last;
  logic [WALK_W-1:0] best_sum, split_at;
  logic              f_is_alloc, f_ext;
  logic [CNT_W-1:0]  f_len_raw, f_room, f_len;
  logic [CNT_W:0]    f_free_sum;
  logic [CNT_W-1:0]  f_next_room, f_next_len;
  logic              w_last, out_load;

  bfa_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_BLOCKS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd       = entry_t'(ram_rdata);
  assign in_fire  = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == S_IDLE);

  // round up to whole blocks
  assign bytes_up = {1'b0, in_req.request_bytes} + (BYTES_W + 1)'(BLOCK_BYTES - 1);
  assign need_c   = NEED_W'(bytes_up >> BLOCK_SHIFT);

  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_clamped = CNT_W'(1);
    end else if (cfg_wr_data > CNT_W'(NUM_BLOCKS)) begin
      cfg_clamped = CNT_W'(NUM_BLOCKS);
    end else begin
      cfg_clamped = cfg_wr_data;
    end
  end

  // best-fit walk
  assign a_end   = walk_r >= {1'b0, active_r};
  assign a_skip  = rd.mid || (rd.val == '0);
  assign a_hit   = !rd.alloc && ({1'b0, rd.val} >= need_r) &&
                   (!found_r || (rd.val < best_len_r));
  assign a_exact = a_hit && ({1'b0, rd.val} == need_r);
  assign best_sum = {2'b00, best_r} + {1'b0, best_len_r};
  assign split_at = {2'b00, best_r} + WALK_W'(need_r);
  assign a_wr_last = ({1'b0, wptr_r} + WALK_W'(1) >= best_sum) ||
                     (wptr_r + CNT_W'(1) >= active_r);

  // free: released run and its neighbors
  assign f_is_alloc = rd.alloc && !rd.mid;
  assign f_len_raw  = (rd.val == '0) ? CNT_W'(1) : rd.val;
  assign f_room     = active_r - {1'b0, rel_r};
  assign f_len      = (f_len_raw > f_room) ? f_room : f_len_raw;
  assign f_free_sum = {1'b0, free_total_r} + {1'b0, f_len};
  assign f_ext      = run_end_r < active_r;
  assign f_next_room = active_r - run_end_r;
  assign f_next_len  = (rd.val > f_next_room) ? f_next_room : rd.val;

  assign w_last   = (wptr_r + CNT_W'(1)) >= ((state_r == S_INIT) ? active_r : run_end_r);
  assign out_load = (state_r == S_RESP) && (!out_valid_r || out_rsp.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (opcode_t'(in_req.opcode) == OP_ALLOC) begin
            if (in_req.request_bytes == '0 || need_c > NEED_W'(free_total_r)) begin
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_A_RD;
            end
          end else if ({1'b0, in_req.release_block} >= active_r) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_F_RD0;
          end
        end
      end
      S_INIT:   if (w_last) state_nxt = S_IDLE;
      S_A_RD:   state_nxt = a_end ? (found_r ? S_A_WR : S_RESP) : S_A_CHK;
      S_A_CHK:  state_nxt = S_A_RD;
      S_A_WR:   if (a_wr_last) state_nxt = S_RESP;
      S_F_RD0:  state_nxt = S_F_CHK0;
      S_F_CHK0: state_nxt = f_is_alloc ? S_F_RD1 : S_RESP;
      S_F_RD1:  state_nxt = f_ext ? S_F_CHK1 : S_F_RD2;
      S_F_CHK1: state_nxt = S_F_RD2;
      S_F_RD2:  state_nxt = (rel_r != '0) ? S_F_CHK2 : S_F_WR;
      S_F_CHK2: state_nxt = S_F_WR;
      S_F_WR:   if (w_last) state_nxt = S_RESP;
      S_RESP:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
    if (cfg_wr_en) begin
      state_nxt = S_INIT;
    end
  end

  // datapath and table access
  always_comb begin
    active_nxt     = active_r;
    free_total_nxt = free_total_r;
    need_nxt       = need_r;
    walk_nxt       = walk_r;
    best_nxt       = best_r;
    best_len_nxt   = best_len_r;
    found_nxt      = found_r;
    rel_nxt        = rel_r;
    run_start_nxt  = run_start_r;
    run_end_nxt    = run_end_r;
    wptr_nxt       = wptr_r;
    status_nxt     = status_r;
    start_blk_nxt  = start_blk_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_free_nxt   = out_free_r;
    ram_we         = 1'b0;
    ram_addr       = wptr_r[IDX_W-1:0];
    ram_wdata      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          need_nxt      = need_c;
          rel_nxt       = in_req.release_block;
          walk_nxt      = '0;
          found_nxt     = 1'b0;
          start_blk_nxt = '0;
          if (opcode_t'(in_req.opcode) == OP_ALLOC) begin
            if (in_req.request_bytes == '0) begin
              status_nxt = ST_ZERO_SIZE;
            end else begin
              status_nxt = ST_LOW_FREE;
            end
          end else begin
            status_nxt = ST_RANGE;
          end
        end
      end
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = (wptr_r == '0) ? entry_t'{1'b0, 1'b0, active_r}
                                   : entry_t'{1'b0, 1'b1, VAL_W'(0)};
        wptr_nxt  = wptr_r + CNT_W'(1);
      end
      S_A_RD: begin
        ram_addr = walk_r[IDX_W-1:0];
        if (a_end) begin
          wptr_nxt   = {1'b0, best_r};
          status_nxt = found_r ? ST_OK : ST_NO_FIT;
        end
      end
      S_A_CHK: begin
        if (a_skip) begin
          walk_nxt = walk_r + WALK_W'(1);
        end else begin
          if (a_hit) begin
            found_nxt    = 1'b1;
            best_nxt     = walk_r[IDX_W-1:0];
            best_len_nxt = rd.val;
          end
          // an exact fit ends the walk
          walk_nxt = a_exact ? WALK_W'(NUM_BLOCKS * 2) : walk_r + {1'b0, rd.val};
        end
      end
      S_A_WR: begin
        ram_we = 1'b1;
        if (wptr_r == {1'b0, best_r}) begin
          ram_wdata = entry_t'{1'b1, 1'b0, VAL_W'(need_r)};
        end else if ({1'b0, wptr_r} < split_at) begin
          ram_wdata = entry_t'{1'b1, 1'b1, VAL_W'(best_r)};
        end else if ({1'b0, wptr_r} == split_at) begin
          ram_wdata = entry_t'{1'b0, 1'b0, best_len_r - VAL_W'(need_r)};
        end else begin
          ram_wdata = entry_t'{1'b0, 1'b1, VAL_W'(split_at)};
        end
        wptr_nxt = wptr_r + CNT_W'(1);
        if (a_wr_last) begin
          free_total_nxt = free_total_r - CNT_W'(need_r);
          start_blk_nxt  = best_r;
        end
      end
      S_F_RD0: begin
        ram_addr = rel_r;
      end
      S_F_CHK0: begin
        if (f_is_alloc) begin
          free_total_nxt = (f_free_sum > {1'b0, active_r}) ? active_r : f_free_sum[CNT_W-1:0];
          run_start_nxt  = rel_r;
          run_end_nxt    = {1'b0, rel_r} + f_len;
          status_nxt     = ST_OK;
        end else begin
          status_nxt = ST_NOT_START;
        end
      end
      S_F_RD1: begin
        ram_addr = run_end_r[IDX_W-1:0];
      end
      S_F_CHK1: begin
        if (!rd.alloc && !rd.mid) begin
          run_end_nxt = run_end_r + f_next_len;
        end
      end
      S_F_RD2: begin
        ram_addr = rel_r - IDX_W'(1);
        wptr_nxt = {1'b0, run_start_r};
      end
      S_F_CHK2: begin
        if (!rd.alloc && !rd.mid) begin
          run_start_nxt = rel_r - IDX_W'(1);
        end else if (!rd.alloc && rd.mid && (rd.val < {1'b0, rel_r})) begin
          run_start_nxt = rd.val[IDX_W-1:0];
        end
        wptr_nxt = {1'b0, run_start_nxt};
      end
      S_F_WR: begin
        ram_we    = 1'b1;
        ram_wdata = (wptr_r == {1'b0, run_start_r})
                    ? entry_t'{1'b0, 1'b0, run_end_r - {1'b0, run_start_r}}
                    : entry_t'{1'b0, 1'b1, VAL_W'(run_start_r)};
        wptr_nxt  = wptr_r + CNT_W'(1);
      end
      S_RESP: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_start_nxt  = start_blk_r;
          out_free_nxt   = free_total_r;
        end
      end
      default: begin
      end
    endcase

    if (cfg_wr_en) begin
      active_nxt     = cfg_clamped;
      free_total_nxt = cfg_clamped;
      wptr_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      active_r     <= CNT_W'(NUM_BLOCKS);
      free_total_r <= CNT_W'(NUM_BLOCKS);
      wptr_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      free_total_r <= free_total_nxt;
      wptr_r       <= wptr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r       <= need_nxt;
    walk_r       <= walk_nxt;
    best_r       <= best_nxt;
    best_len_r   <= best_len_nxt;
    found_r      <= found_nxt;
    rel_r        <= rel_nxt;
    run_start_r  <= run_start_nxt;
    run_end_r    <= run_end_nxt;
    status_r     <= status_nxt;
    start_blk_r  <= start_blk_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_rsp.valid            = out_valid_r;
  assign out_rsp.status           = out_status_r;
  assign out_rsp.start_block      = out_start_r;
  assign out_rsp.free_block_count = out_free_r;

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r <= active_r)
    else $error("free count above active blocks");

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_INIT || state_r == S_A_WR || state_r == S_F_WR))
    else $error("table write outside a write sweep");

  a_resp_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result lost at output register");

  a_start_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_OK) |-> ({1'b0, out_start_r} < active_r))
    else $error("start block beyond active blocks");

endmodule

// File: hw/rtl/bfa_ram.sv
`timescale 1ns / 1ps
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: test/best_fit_block_allocator_tb.sv
`timescale 1ns / 1ps
module best_fit_block_allocator_tb;
  import bfa_pkg::*;

  localparam int DIR_MAX_BLOCKS = 4096;
  localparam int IDLE_LIMIT     = 60000;

  typedef struct {
    status_t     st;
    logic [11:0] blk;
    logic [12:0] cnt;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [12:0] cfg_wr_data = '0;

  bfa_req_if in_req ();
  bfa_rsp_if out_rsp ();

  best_fit_block_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req.sink),
    .out_rsp    (out_rsp.source),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the block table
  logic tbl_alloc [DIR_MAX_BLOCKS];
  logic tbl_mid [DIR_MAX_BLOCKS];
  int   tbl_val [DIR_MAX_BLOCKS];
  int   pool_blocks;
  int   free_blocks;
  int   live_starts[$];
  alloc_rsp_t pending_rsp[$];

  int mismatches = 0;
  int status_hits[6];
  int accepted_items = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  function automatic void write_run(int start, int len, logic is_alloc);
    if (start >= pool_blocks || len == 0) return;
    tbl_alloc[start] = is_alloc;
    tbl_mid[start]   = 1'b0;
    tbl_val[start]   = len;
    for (int i = start + 1; i < start + len && i < pool_blocks; i++) begin
      tbl_alloc[i] = is_alloc;
      tbl_mid[i]   = 1'b1;
      tbl_val[i]   = start;
    end
  endfunction

  function automatic void load_pool(logic [12:0] value);
    pool_blocks = (value == 0) ? 1 : (value > NUM_BLOCKS) ? NUM_BLOCKS : int'(value);
    write_run(0, pool_blocks, 1'b0);
    free_blocks = pool_blocks;
    live_starts.delete();
  endfunction

  function automatic status_t alloc_blocks(logic [21:0] bytes, output int start_out);
    int need, i, best, best_len;
    logic found;
    need = 0; i = 0; best = 0; best_len = 0; found = 1'b0;
    start_out = 0;
    if (bytes == 0) return ST_ZERO_SIZE;
    need = (int'(bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    if (need > free_blocks) return ST_LOW_FREE;
    while (i < pool_blocks) begin
      if (tbl_mid[i] || tbl_val[i] == 0) begin
        i++;
        continue;
      end
      if (!tbl_alloc[i] && tbl_val[i] >= need) begin
        if (!found || tbl_val[i] < best_len) begin
          found = 1'b1;
          best = i;
          best_len = tbl_val[i];
          if (best_len == need) break;
        end
      end
      i += tbl_val[i];
    end
    if (!found) return ST_NO_FIT;
    if (best_len > need) write_run(best + need, best_len - need, 1'b0);
    write_run(best, need, 1'b1);
    free_blocks -= need;
    start_out = best;
    return ST_OK;
  endfunction

  function automatic status_t release_blocks(int s);
    int len, first, last, nl, ps;
    if (s >= pool_blocks) return ST_RANGE;
    if (!(tbl_alloc[s] && !tbl_mid[s])) return ST_NOT_START;
    len = (tbl_val[s] == 0) ? 1 : tbl_val[s];
    if (len > pool_blocks - s) len = pool_blocks - s;
    free_blocks += len;
    if (free_blocks > pool_blocks) free_blocks = pool_blocks;
    first = s;
    last = s + len;
    if (last < pool_blocks && !tbl_alloc[last] && !tbl_mid[last]) begin
      nl = tbl_val[last];
      if (nl > pool_blocks - last) nl = pool_blocks - last;
      last += nl;
    end
    if (s > 0) begin
      if (!tbl_alloc[s-1] && !tbl_mid[s-1]) begin
        first = s - 1;
      end else if (!tbl_alloc[s-1] && tbl_mid[s-1]) begin
        ps = tbl_val[s-1];
        if (ps < s) first = ps;
      end
    end
    write_run(first, last - first, 1'b0);
    return ST_OK;
  endfunction

  function automatic alloc_rsp_t predict_request(opcode_t op, logic [21:0] bytes,
                                                 logic [11:0] rel);
    alloc_rsp_t r;
    int s;
    s = 0;
    if (op == OP_ALLOC) begin
      r.st = alloc_blocks(bytes, s);
      if (r.st == ST_OK) live_starts.push_back(s);
    end else begin
      r.st = release_blocks(int'(rel));
      if (r.st == ST_OK)
        foreach (live_starts[k])
          if (live_starts[k] == int'(rel)) begin
            live_starts.delete(k);
            break;
          end
    end
    r.blk = (op == OP_ALLOC) ? s[11:0] : 12'd0;
    r.cnt = free_blocks[12:0];
    return r;
  endfunction

  task automatic send_request(opcode_t op, logic [21:0] bytes, logic [11:0] rel);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_req.valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_req.valid         = 1'b1;
    in_req.opcode        = op;
    in_req.request_bytes = bytes;
    in_req.release_block = rel;
    do @(posedge clk); while (!in_req.ready);
    pending_rsp.push_back(predict_request(op, bytes, rel));
    accepted_items++;
  endtask

  task automatic wait_all_done();
    @(negedge clk);
    in_req.valid = 1'b0;
    burst_left = 0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_pool_size(logic [12:0] value);
    wait_all_done();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    load_pool(value);
  endtask

  task automatic alloc_bytes(logic [21:0] bytes);
    send_request(OP_ALLOC, bytes, '0);
  endtask

  task automatic free_block(logic [11:0] blk);
    send_request(OP_FREE, '0, blk);
  endtask

  task automatic test_directed();
    alloc_bytes(22'd0);
    alloc_bytes(22'd1);
    alloc_bytes(22'd512);
    alloc_bytes(22'd513);
    alloc_bytes(22'd2097152);
    alloc_bytes(22'h3FFFFF);
    free_block(12'd4095);
    free_block(12'd2);
    free_block(12'd1);
    free_block(12'd0);
    free_block(12'd3);
    free_block(12'd0);
    // small pool: fill it, overflow, then fragment for a no-fit
    write_pool_size(13'd8);
    alloc_bytes(22'd4096);
    alloc_bytes(22'd1);
    free_block(12'd0);
    free_block(12'd9);
    for (int k = 0; k < 4; k++) alloc_bytes(22'd1024);
    free_block(12'd0);
    free_block(12'd4);
    alloc_bytes(22'd1536);
    free_block(12'd5);
    free_block(12'd2);
  endtask

  task automatic test_register_extremes();
    write_pool_size(13'd0);
    alloc_bytes(22'd512);
    free_block(12'd0);
    free_block(12'd1);
    write_pool_size(13'h1FFF);
    alloc_bytes(22'd2097152);
    free_block(12'd0);
  endtask

  task automatic test_random_phase(logic [12:0] pool, int count, int max_need);
    int sel, need;
    write_pool_size(pool);
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        need = $urandom_range(1, max_need);
        alloc_bytes(22'(need * BLOCK_BYTES - $urandom_range(0, BLOCK_BYTES - 1)));
      end else if (sel < 85 && live_starts.size() != 0) begin
        free_block(12'(live_starts[$urandom_range(0, live_starts.size() - 1)]));
      end else if (sel < 90) begin
        free_block(12'($urandom_range(0, pool_blocks - 1)));
      end else if (sel < 94) begin
        free_block(12'($urandom_range(0, 4095)));
      end else if (sel < 97) begin
        alloc_bytes(22'($urandom_range(0, 22'h3FFFFF)));
      end else begin
        alloc_bytes(22'd0);
      end
    end
  endtask

  // hold off until the pipeline is empty, then restart mid-pool
  task automatic test_drain_pause();
    wait_all_done();
    alloc_bytes(22'd700);
    if (live_starts.size() != 0) free_block(12'(live_starts[0]));
  endtask

  // response checker and idle watchdog
  always @(posedge clk) begin
    alloc_rsp_t exp_rsp;
    if (rst_n) begin
      if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d results still outstanding", pending_rsp.size());
        $display("best_fit_block_allocator verification failed");
        $finish;
      end
      if (out_rsp.valid && out_rsp.ready) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction");
        end else begin
          exp_rsp = pending_rsp.pop_front();
          if (out_rsp.status < 6) status_hits[out_rsp.status]++;
          if (out_rsp.status !== exp_rsp.st || out_rsp.start_block !== exp_rsp.blk ||
              out_rsp.free_block_count !== exp_rsp.cnt) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d blk=%0d cnt=%0d got st=%0d blk=%0d cnt=%0d",
                       exp_rsp.st, exp_rsp.blk, exp_rsp.cnt, out_rsp.status,
                       out_rsp.start_block, out_rsp.free_block_count);
          end
        end
      end
    end
  end

  // receiver stalls on a pattern picked at random from four modes
  int rx_cycle = 0;
  int rx_mode = 0;
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_rsp.ready = 1'b1;
      1: out_rsp.ready = $urandom_range(0, 1);
      2: out_rsp.ready = (rx_cycle % 8) < 2;
      default: out_rsp.ready = $urandom_range(0, 3) == 0;
    endcase
  end

  initial begin
    in_req.valid         = 1'b0;
    in_req.opcode        = OP_ALLOC;
    in_req.request_bytes = '0;
    in_req.release_block = '0;
    out_rsp.ready        = 1'b1;
    load_pool(13'd4096);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_register_extremes();
    test_random_phase(13'd1, 20, 2);
    test_random_phase(13'd7, 60, 3);
    test_random_phase(13'd33, 100, 6);
    test_drain_pause();
    test_random_phase(13'd200, 120, 24);
    test_random_phase(13'd4096, 40, 64);
    wait_all_done();
    repeat (20) @(posedge clk);

    $display("covered %0d transactions over pool sizes 1 to 4096", accepted_items);
    $display("status counts ok=%0d low=%0d nofit=%0d range=%0d notstart=%0d zero=%0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5]);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("best_fit_block_allocator verification clean");
    end else begin
      $display("best_fit_block_allocator verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_if.sv
hw/rtl/bfa_ram.sv
hw/rtl/best_fit_block_allocator.sv
test/best_fit_block_allocator_tb.sv
